// ===== sv/hsd_pkg.sv =====
// Shared types, constants and bin quantisers for the HSV histogram shot detector.
package hsd_pkg;

  localparam int BIN_COUNT  = 22;
  localparam int SAT_BASE   = 12;
  localparam int VAL_BASE   = 17;
  localparam int HUE_DIV    = 21;
  localparam int SV_DIV     = 51;
  localparam int HUE_TOP    = 11;
  localparam int SV_TOP     = 4;
  localparam int IDX_W      = $clog2(BIN_COUNT);
  localparam int CNT_W      = 22;
  localparam int MAX_PIXELS = 2097152;
  localparam int ACC_W      = 28;
  localparam int THR_W      = 9;
  localparam int THR10_W    = THR_W + 4;
  localparam int RHS_W      = THR10_W + CNT_W;
  localparam int OVL_W      = 25;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

  // Shared unit operations
  localparam logic OP_INC = 1'b0;
  localparam logic OP_ACC = 1'b1;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [OVL_W-1:0] weighted_overlap;
    logic [CNT_W-1:0] pixel_total;
    logic             same_shot;
    logic             first_frame;
    logic             overflow;
  } out_item_t;

  // Histogram store control from the sequencer
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             inc_we;
    logic             roll;
  } hist_ctl_t;

  // Hue bin: min(h/21, 11) from parallel threshold compares
  function automatic logic [IDX_W-1:0] hue_bin(input logic [7:0] h);
    logic [IDX_W-1:0] q;
    q = '0;
    for (int k = 1; k <= HUE_TOP; k++) begin
      if (h >= 8'(HUE_DIV * k)) q = IDX_W'(k);
    end
    return q;
  endfunction

  // Saturation / value bin: min(x/51, 4)
  function automatic logic [IDX_W-1:0] sv_bin(input logic [7:0] x);
    logic [IDX_W-1:0] q;
    q = '0;
    for (int k = 1; k <= SV_TOP; k++) begin
      if (x >= 8'(SV_DIV * k)) q = IDX_W'(k);
    end
    return q;
  endfunction

endpackage

// ===== sv/hsv_histogram_shot_detector.sv =====
// Top level: pixel sequencer, frame-end histogram walk and result register.
// Sequence: a pixel is accepted, then its hue, saturation and value bins are updated in turn
// through the shared adder; a frame end then walks all 22 bins, multiplies and registers the result.
// Input stalls until the sequencer is back in idle, so a new pixel is taken only after the last
// one is through; a held result stalls input.
// Reset (synchronous, rst_n low): histograms, counters and flags clear, threshold 205.
module hsv_histogram_shot_detector (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  hsd_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output hsd_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [hsd_pkg::THR_W-1:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HUE  = 3'd1;
  localparam logic [2:0] S_SAT  = 3'd2;
  localparam logic [2:0] S_VAL  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]                state_r, state_nxt;
  logic [hsd_pkg::IDX_W-1:0] hue_idx_r, sat_idx_r, val_idx_r;
  logic                      last_r;
  logic [hsd_pkg::IDX_W-1:0] walk_idx_r, walk_idx_nxt;
  logic [hsd_pkg::CNT_W-1:0] pix_cnt_r, pix_cnt_nxt;
  logic                      sat_flag_r, sat_flag_nxt;
  logic                      have_prev_r, have_prev_nxt;
  logic [hsd_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [hsd_pkg::RHS_W-1:0] rhs_r;
  logic [hsd_pkg::THR_W-1:0] thr_r;
  logic                      out_valid_r;
  hsd_pkg::out_item_t        out_item_r;

  hsd_pkg::hist_ctl_t        ctl;
  logic                      unit_op;
  logic [hsd_pkg::CNT_W-1:0] cur_rd, prev_rd;
  logic [hsd_pkg::ACC_W-1:0] unit_sum;
  logic                      at_max;
  logic                      in_acc;
  logic                      inc_state;
  logic                      emit;
  logic [hsd_pkg::THR10_W-1:0] thr10;
  logic [hsd_pkg::RHS_W-1:0] prod;
  logic                      same;

  hsd_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .wdata   (unit_sum[hsd_pkg::CNT_W-1:0]),
    .cur_rd  (cur_rd),
    .prev_rd (prev_rd)
  );

  hsd_unit u_unit (
    .op       (unit_op),
    .idx      (ctl.idx),
    .cur_val  (cur_rd),
    .prev_val (prev_rd),
    .acc      (acc_r),
    .sum      (unit_sum),
    .at_max   (at_max)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign inc_state = (state_r == S_HUE) || (state_r == S_SAT) || (state_r == S_VAL);
  assign emit      = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Threshold times ten, then times the pixel count
  assign thr10 = (hsd_pkg::THR10_W'(thr_r) << 3) + (hsd_pkg::THR10_W'(thr_r) << 1);
  assign prod  = hsd_pkg::RHS_W'(thr10) * hsd_pkg::RHS_W'(pix_cnt_r);
  assign same  = have_prev_r &&
                 ({acc_r, 8'b0} >= (hsd_pkg::ACC_W + 8)'(rhs_r));

  // Steer the bin port and shared adder
  always_comb begin
    ctl.roll   = (state_r == S_WALK);
    ctl.inc_we = inc_state && !at_max;
    unit_op    = (state_r == S_WALK) ? hsd_pkg::OP_ACC : hsd_pkg::OP_INC;
    unique case (state_r)
      S_HUE:   ctl.idx = hue_idx_r;
      S_SAT:   ctl.idx = sat_idx_r;
      S_VAL:   ctl.idx = val_idx_r;
      S_WALK:  ctl.idx = walk_idx_r;
      default: ctl.idx = '0;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    walk_idx_nxt  = walk_idx_r;
    pix_cnt_nxt   = pix_cnt_r;
    sat_flag_nxt  = sat_flag_r;
    have_prev_nxt = have_prev_r;
    acc_nxt       = acc_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (pix_cnt_r < hsd_pkg::CNT_MAX) pix_cnt_nxt = pix_cnt_r + 1'b1;
          else sat_flag_nxt = 1'b1;
          state_nxt = S_HUE;
        end
      end
      S_HUE: begin
        if (at_max) sat_flag_nxt = 1'b1;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        if (at_max) sat_flag_nxt = 1'b1;
        state_nxt = S_VAL;
      end
      S_VAL: begin
        if (at_max) sat_flag_nxt = 1'b1;
        walk_idx_nxt = '0;
        acc_nxt      = '0;
        state_nxt    = last_r ? S_WALK : S_IDLE;
      end
      S_WALK: begin
        acc_nxt = unit_sum;
        if (walk_idx_r == hsd_pkg::IDX_W'(hsd_pkg::BIN_COUNT - 1)) begin
          state_nxt = S_MUL;
        end else begin
          walk_idx_nxt = walk_idx_r + 1'b1;
        end
      end
      S_MUL: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (emit) begin
          pix_cnt_nxt   = '0;
          sat_flag_nxt  = 1'b0;
          have_prev_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      walk_idx_r  <= '0;
      pix_cnt_r   <= '0;
      sat_flag_r  <= 1'b0;
      have_prev_r <= 1'b0;
      thr_r       <= hsd_pkg::THR_W'(205);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_idx_r  <= walk_idx_nxt;
      pix_cnt_r   <= pix_cnt_nxt;
      sat_flag_r  <= sat_flag_nxt;
      have_prev_r <= have_prev_nxt;
      if (cfg_we) thr_r <= cfg_wdata;
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Payload registers: pixel bins, accumulator, product, result
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (in_acc) begin
      hue_idx_r <= hsd_pkg::hue_bin(in_item.hue);
      sat_idx_r <= hsd_pkg::IDX_W'(hsd_pkg::SAT_BASE) + hsd_pkg::sv_bin(in_item.saturation);
      val_idx_r <= hsd_pkg::IDX_W'(hsd_pkg::VAL_BASE) + hsd_pkg::sv_bin(in_item.brightness);
      last_r    <= in_item.frame_end;
    end
    if (state_r == S_MUL) rhs_r <= prod;
    if (emit) begin
      out_item_r.weighted_overlap <= acc_r[hsd_pkg::OVL_W-1:0];
      out_item_r.pixel_total      <= pix_cnt_r;
      out_item_r.same_shot        <= same;
      out_item_r.first_frame      <= !have_prev_r;
      out_item_r.overflow         <= sat_flag_r;
    end
  end

  // Checks
  a_first_not_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.first_frame && out_item.same_shot))
    else $error("first frame reported as same shot");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pix_cnt_r <= hsd_pkg::CNT_MAX)
    else $error("pixel counter beyond its limit");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (pix_cnt_r == '0) && !sat_flag_r && have_prev_r)
    else $error("frame state not cleared after result");

  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (walk_idx_r < hsd_pkg::IDX_W'(hsd_pkg::BIN_COUNT)))
    else $error("walk index out of range");

endmodule

// ===== sv/hsd_unit.sv =====
// Shared adder: saturating bin increment or weighted-minimum accumulate.
module hsd_unit (
  input  logic                     op,
  input  logic [hsd_pkg::IDX_W-1:0] idx,
  input  logic [hsd_pkg::CNT_W-1:0] cur_val,
  input  logic [hsd_pkg::CNT_W-1:0] prev_val,
  input  logic [hsd_pkg::ACC_W-1:0] acc,
  output logic [hsd_pkg::ACC_W-1:0] sum,
  output logic                     at_max
);

  logic [hsd_pkg::CNT_W-1:0] min_v;
  logic [hsd_pkg::ACC_W-1:0] min_w;
  logic [hsd_pkg::ACC_W-1:0] wmin;
  logic [hsd_pkg::ACC_W-1:0] opa;
  logic [hsd_pkg::ACC_W-1:0] opb;

  // Bin-wise minimum, weighted 5/3/2 by group with shift-adds
  always_comb begin
    min_v = (cur_val < prev_val) ? cur_val : prev_val;
    min_w = hsd_pkg::ACC_W'(min_v);
    if (idx < hsd_pkg::IDX_W'(hsd_pkg::SAT_BASE)) begin
      wmin = (min_w << 2) + min_w;
    end else if (idx < hsd_pkg::IDX_W'(hsd_pkg::VAL_BASE)) begin
      wmin = (min_w << 1) + min_w;
    end else begin
      wmin = min_w << 1;
    end
  end

  // Select operands for the one adder
  always_comb begin
    if (op == hsd_pkg::OP_ACC) begin
      opa = acc;
      opb = wmin;
    end else begin
      opa = hsd_pkg::ACC_W'(cur_val);
      opb = hsd_pkg::ACC_W'(1);
    end
    sum    = opa + opb;
    at_max = (cur_val >= hsd_pkg::CNT_MAX);
  end

endmodule

// ===== sv/hsd_hist.sv =====
// Current and previous frame histograms with one indexed read and update.
module hsd_hist (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hsd_pkg::hist_ctl_t        ctl,
  input  logic [hsd_pkg::CNT_W-1:0] wdata,
  output logic [hsd_pkg::CNT_W-1:0] cur_rd,
  output logic [hsd_pkg::CNT_W-1:0] prev_rd
);

  logic [hsd_pkg::CNT_W-1:0] cur_r  [hsd_pkg::BIN_COUNT];
  logic [hsd_pkg::CNT_W-1:0] prev_r [hsd_pkg::BIN_COUNT];

  // Read the selected bin of both frames
  assign cur_rd  = cur_r[ctl.idx];
  assign prev_rd = prev_r[ctl.idx];

  // Increment a bin, or roll it into the previous frame and clear it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hsd_pkg::BIN_COUNT; i++) begin
        cur_r[i]  <= '0;
        prev_r[i] <= '0;
      end
    end else if (ctl.roll) begin
      prev_r[ctl.idx] <= cur_r[ctl.idx];
      cur_r[ctl.idx]  <= '0;
    end else if (ctl.inc_we) begin
      cur_r[ctl.idx] <= wdata;
    end
  end

endmodule
